>>> rtl/core/metronome_click_synth_defines.svh
`ifndef METRONOME_CLICK_SYNTH_DEFINES_SVH
`define METRONOME_CLICK_SYNTH_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define MCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("click synth check failed");

// Next-cycle implication, disabled while reset is held
`define MCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("click synth check failed");

`endif

>>> rtl/core/mcs_pkg.sv
package mcs_pkg;

  // Default parameter values
  localparam int DEF_SINE_TABLE_DEPTH     = 1024;
  localparam int DEF_ENVELOPE_TABLE_DEPTH = 1024;
  localparam int DEF_POSITION_BITS        = 48;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BEAT_PERIOD   = 3'd0,
    CFG_BEATS_PER_BAR = 3'd1,
    CFG_CLICK_LENGTH  = 3'd2,
    CFG_STRONG_STEP   = 3'd3,
    CFG_WEAK_STEP     = 3'd4,
    CFG_DECAY_STEP    = 3'd5
  } cfg_idx_t;

  // Register reset values
  localparam logic [31:0] RST_BEAT_PERIOD   = 32'd98304000;
  localparam logic [6:0]  RST_BEATS_PER_BAR = 7'd4;
  localparam logic [19:0] RST_CLICK_LENGTH  = 20'd1440;
  localparam logic [31:0] RST_STRONG_STEP   = 32'd134217728;
  localparam logic [31:0] RST_WEAK_STEP     = 32'd89478485;
  localparam logic [23:0] RST_DECAY_STEP    = 24'd27962;
  localparam logic [6:0]  BPB_FALLBACK      = 7'd4;

  // Settings seen by the datapath (beats per bar already has the fallback applied)
  typedef struct packed {
    logic [31:0] beat_period;
    logic [6:0]  bpb;
    logic [19:0] click_length;
    logic [31:0] strong_step;
    logic [31:0] weak_step;
    logic [23:0] decay_step;
  } cfg_t;

endpackage

>>> rtl/core/mcs_in_if.sv
interface mcs_in_if #(
  parameter int POSITION_BITS = mcs_pkg::DEF_POSITION_BITS
) ();
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] sample_position;
  logic                            frame_last;

  modport source (output valid, sample_position, frame_last, input ready);
  modport sink   (input valid, sample_position, frame_last, output ready);
endinterface

>>> rtl/core/mcs_out_if.sv
interface mcs_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] click_sample;
  logic               accent_flag;
  logic               last_out;

  modport source (output valid, click_sample, accent_flag, last_out, input ready);
  modport sink   (input valid, click_sample, accent_flag, last_out, output ready);
endinterface

>>> rtl/core/metronome_click_synth.sv
// Metronome click synthesizer.
// in_chan carries one signed sample position and a frame_last mark per transfer;
// out_chan returns one click sample (Q1.15), an accent flag and the copied mark,
// in input order. Both channels transfer when valid and ready are high at a
// rising edge of clk. Settings are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no item is in flight, which the block
// does not enforce; index codes follow mcs_pkg::cfg_idx_t. The pipeline is the
// entry register, the divider, which resolves one quotient bit per stage over
// POSITION_BITS + 12 stages, nine tone stages and the output register.
// Throughput: one item per cycle while the skid register is empty.
// When the receiver stalls, a skid register catches the item leaving the
// pipeline and the whole pipeline then holds; in_chan.ready drops until the
// skid register drains. Synchronous active-low reset empties all stages and
// loads the default tempo settings; the tables are constants.
`include "metronome_click_synth_defines.svh"

module metronome_click_synth #(
  parameter int SINE_TABLE_DEPTH     = mcs_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int ENVELOPE_TABLE_DEPTH = mcs_pkg::DEF_ENVELOPE_TABLE_DEPTH,
  parameter int POSITION_BITS        = mcs_pkg::DEF_POSITION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mcs_in_if.sink                          in_chan,
  mcs_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [mcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [31:0] beat_period_r;
  logic [6:0]  bpb_r;
  logic [19:0] click_length_r;
  logic [31:0] strong_step_r;
  logic [31:0] weak_step_r;
  logic [23:0] decay_step_r;
  mcs_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_period_r  <= mcs_pkg::RST_BEAT_PERIOD;
      bpb_r          <= mcs_pkg::RST_BEATS_PER_BAR;
      click_length_r <= mcs_pkg::RST_CLICK_LENGTH;
      strong_step_r  <= mcs_pkg::RST_STRONG_STEP;
      weak_step_r    <= mcs_pkg::RST_WEAK_STEP;
      decay_step_r   <= mcs_pkg::RST_DECAY_STEP;
    end else if (cfg_we) begin
      case (mcs_pkg::cfg_idx_t'(cfg_index))
        mcs_pkg::CFG_BEAT_PERIOD:   beat_period_r  <= cfg_data;
        mcs_pkg::CFG_BEATS_PER_BAR: bpb_r          <= cfg_data[6:0];
        mcs_pkg::CFG_CLICK_LENGTH:  click_length_r <= cfg_data[19:0];
        mcs_pkg::CFG_STRONG_STEP:   strong_step_r  <= cfg_data;
        mcs_pkg::CFG_WEAK_STEP:     weak_step_r    <= cfg_data;
        mcs_pkg::CFG_DECAY_STEP:    decay_step_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.beat_period  = beat_period_r;
    cfg.bpb          = (bpb_r == 7'd0) ? mcs_pkg::BPB_FALLBACK : bpb_r;
    cfg.click_length = click_length_r;
    cfg.strong_step  = strong_step_r;
    cfg.weak_step    = weak_step_r;
    cfg.decay_step   = decay_step_r;
  end

  // Whole pipeline advances unless the skid register is occupied
  logic pipe_en;
  logic skid_v_r;
  logic out_v_r;

  assign pipe_en       = !skid_v_r;
  assign in_chan.ready = pipe_en;

  // Entry stage: split sign and magnitude
  logic [POSITION_BITS-1:0] raw;
  logic [POSITION_BITS-1:0] mag_nxt;
  logic [POSITION_BITS-1:0] s0_mag_r;
  logic                     s0_v_r, s0_neg_r, s0_last_r;

  always_comb begin
    raw     = POSITION_BITS'(in_chan.sample_position);
    mag_nxt = raw[POSITION_BITS-1] ? (~raw + POSITION_BITS'(1)) : raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (pipe_en) begin
      s0_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_mag_r  <= mag_nxt;
      s0_neg_r  <= raw[POSITION_BITS-1];
      s0_last_r <= in_chan.frame_last;
    end
  end

  // Beat division
  logic        div_v, div_neg, div_last;
  logic [31:0] div_rem;
  logic [6:0]  div_q;

  mcs_divider #(
    .POSITION_BITS (POSITION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .cfg      (cfg),
    .in_v     (s0_v_r),
    .in_mag   (s0_mag_r),
    .in_neg   (s0_neg_r),
    .in_last  (s0_last_r),
    .out_v    (div_v),
    .out_rem  (div_rem),
    .out_q    (div_q),
    .out_neg  (div_neg),
    .out_last (div_last)
  );

  // Click tone
  logic               tone_v, tone_accent, tone_last;
  logic signed [15:0] tone_sample;

  mcs_tone #(
    .SINE_TABLE_DEPTH     (SINE_TABLE_DEPTH),
    .ENVELOPE_TABLE_DEPTH (ENVELOPE_TABLE_DEPTH)
  ) u_tone (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .cfg        (cfg),
    .in_v       (div_v),
    .in_rem     (div_rem),
    .in_q       (div_q),
    .in_neg     (div_neg),
    .in_last    (div_last),
    .out_v      (tone_v),
    .out_sample (tone_sample),
    .out_accent (tone_accent),
    .out_last   (tone_last)
  );

  // Output register with skid register behind it
  logic signed [15:0] out_sample_r, skid_sample_r;
  logic               out_accent_r, skid_accent_r;
  logic               out_last_r, skid_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pipe_en) begin
      if (tone_v) begin
        if (!out_v_r || out_chan.ready) begin
          out_v_r      <= 1'b1;
          out_sample_r <= tone_sample;
          out_accent_r <= tone_accent;
          out_last_r   <= tone_last;
        end else begin
          skid_v_r      <= 1'b1;
          skid_sample_r <= tone_sample;
          skid_accent_r <= tone_accent;
          skid_last_r   <= tone_last;
        end
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end else if (out_chan.ready) begin
      skid_v_r     <= 1'b0;
      out_sample_r <= skid_sample_r;
      out_accent_r <= skid_accent_r;
      out_last_r   <= skid_last_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.click_sample = out_sample_r;
  assign out_chan.accent_flag  = out_accent_r;
  assign out_chan.last_out     = out_last_r;

  // Checks
  `MCS_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `MCS_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_v_r && out_chan.ready, !skid_v_r)
  `MCS_ASSERT_NXT(a_stall_holds_tail, clk, rst_n, !pipe_en, $stable(tone_v))

endmodule

>>> rtl/core/mcs_divider.sv
// Restoring divider of mag * 4096 by the beat period, one quotient bit per stage.
// The quotient is kept only modulo beats per bar.
module mcs_divider #(
  parameter int POSITION_BITS = mcs_pkg::DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  mcs_pkg::cfg_t            cfg,
  input  logic                     in_v,
  input  logic [POSITION_BITS-1:0] in_mag,
  input  logic                     in_neg,
  input  logic                     in_last,
  output logic                     out_v,
  output logic [31:0]              out_rem,
  output logic [6:0]               out_q,
  output logic                     out_neg,
  output logic                     out_last
);

  localparam int DIV_STAGES = POSITION_BITS + 12;

  typedef struct packed {
    logic                     v;
    logic [31:0]              rem;
    logic [6:0]               q;
    logic [POSITION_BITS-1:0] sh;
    logic                     neg;
    logic                     last;
  } div_stage_t;

  div_stage_t st_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    div_stage_t prev;
    div_stage_t st_nxt;
    logic [32:0] rem2;
    logic [32:0] diff;
    logic        ge;
    logic [7:0]  q2;

    // Stage input: the entry register or the stage before
    if (j == 0) begin : g_first
      always_comb begin
        prev      = '0;
        prev.v    = in_v;
        prev.sh   = in_mag;
        prev.neg  = in_neg;
        prev.last = in_last;
      end
    end else begin : g_next
      always_comb begin
        prev = st_r[j-1];
      end
    end

    // One shift-compare-subtract step; zeros shift in behind the magnitude
    always_comb begin
      rem2        = {prev.rem, prev.sh[POSITION_BITS-1]};
      diff        = rem2 - {1'b0, cfg.beat_period};
      ge          = (rem2 >= {1'b0, cfg.beat_period});
      q2          = {prev.q, ge};
      st_nxt      = prev;
      st_nxt.sh   = prev.sh << 1;
      st_nxt.rem  = ge ? diff[31:0] : rem2[31:0];
      st_nxt.q    = (q2 >= {1'b0, cfg.bpb}) ? 7'(q2 - {1'b0, cfg.bpb}) : q2[6:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].v <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt;
      end
    end
  end

  assign out_v    = st_r[DIV_STAGES-1].v;
  assign out_rem  = st_r[DIV_STAGES-1].rem;
  assign out_q    = st_r[DIV_STAGES-1].q;
  assign out_neg  = st_r[DIV_STAGES-1].neg;
  assign out_last = st_r[DIV_STAGES-1].last;

endmodule

>>> rtl/core/mcs_tone.sv
// Offset fix-up, click window, phase and envelope, table lookups and scaling.
module mcs_tone #(
  parameter int SINE_TABLE_DEPTH     = mcs_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int ENVELOPE_TABLE_DEPTH = mcs_pkg::DEF_ENVELOPE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  mcs_pkg::cfg_t      cfg,
  input  logic               in_v,
  input  logic [31:0]        in_rem,
  input  logic [6:0]         in_q,
  input  logic               in_neg,
  input  logic               in_last,
  output logic               out_v,
  output logic signed [15:0] out_sample,
  output logic               out_accent,
  output logic               out_last
);

  localparam int SIW           = $clog2(SINE_TABLE_DEPTH);
  localparam int EIW           = $clog2(ENVELOPE_TABLE_DEPTH);
  localparam int INT_EXP_COUNT = 32;
  localparam int IEW           = $clog2(INT_EXP_COUNT);

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_PI      = 64'd3373259426;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;

  localparam logic [14:0] GAIN_STRONG = 15'd29491;
  localparam logic [14:0] GAIN_WEAK   = 15'd19661;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [30:0]        frac_rom_t [ENVELOPE_TABLE_DEPTH];
  typedef logic [30:0]        int_rom_t  [INT_EXP_COUNT];

  // sin(a), a in [0, pi/2], Q30 in and out
  function automatic longint unsigned sin_series(input longint unsigned a);
    longint          sum;
    longint unsigned term;
    sum  = longint'(a);
    term = a;
    for (int k = 1; k <= 12; k++) begin
      term = (((term * a) >> 30) * a) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // exp(-x), x in [0, 1], Q30 in and out
  function automatic longint unsigned exp_neg_series(input longint unsigned x);
    longint          sum;
    longint unsigned term;
    sum  = longint'(Q30_ONE);
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t       t;
    longint unsigned x;
    longint unsigned v;
    logic            neg;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x   = (64'(i) * Q30_TWO_PI) / 64'(SINE_TABLE_DEPTH);
      neg = 1'b0;
      if (x >= Q30_PI) begin
        neg = 1'b1;
        x   = x - Q30_PI;
      end
      if (x > Q30_HALF_PI) begin
        x = Q30_PI - x;
      end
      v = (sin_series(x) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      t[i] = neg ? -16'(v) : 16'(v);
    end
    return t;
  endfunction

  function automatic frac_rom_t build_frac();
    frac_rom_t t;
    for (int i = 0; i < ENVELOPE_TABLE_DEPTH; i++) begin
      t[i] = 31'(exp_neg_series((64'(i) << 30) / 64'(ENVELOPE_TABLE_DEPTH)));
    end
    return t;
  endfunction

  function automatic int_rom_t build_int();
    int_rom_t        t;
    longint unsigned e1;
    longint unsigned acc;
    e1   = exp_neg_series(Q30_ONE);
    acc  = Q30_ONE;
    t[0] = 31'(acc);
    for (int i = 1; i < INT_EXP_COUNT; i++) begin
      acc  = (acc * e1 + 64'd536870912) >> 30;
      t[i] = 31'(acc);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam frac_rom_t FRAC_ROM = build_frac();
  localparam int_rom_t  INT_ROM  = build_int();

  // Valid and last ride along every stage; accent and window flags from where they are set
  logic [8:0] v_r;
  logic [8:0] last_r;

  // T1: negative positions: true floor, so mirror the remainder and step the beat
  logic [31:0] rem1_nxt, rem1_r;
  logic        strong1_nxt, strong1_r;
  logic [6:0]  qinc;

  always_comb begin
    qinc = ((in_q + 7'd1) == cfg.bpb) ? 7'd0 : in_q + 7'd1;
    if (in_neg && (in_rem != 32'd0)) begin
      rem1_nxt    = cfg.beat_period - in_rem;
      strong1_nxt = (qinc == 7'd0);
    end else begin
      rem1_nxt    = in_rem;
      strong1_nxt = (in_q == 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem1_r    <= rem1_nxt;
      strong1_r <= strong1_nxt;
    end
  end

  // T2: click window and tone select
  logic [31:0] rem2_r, step2_r;
  logic        strong2_r, act2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem2_r    <= rem1_r;
      step2_r   <= strong1_r ? cfg.strong_step : cfg.weak_step;
      strong2_r <= strong1_r;
      act2_r    <= (rem1_r < {cfg.click_length, 12'd0}) && (cfg.beat_period != 32'd0);
    end
  end

  // T3: phase and exponent products
  logic [63:0] ps3_r;
  logic [55:0] pe3_r;
  logic        strong3_r, act3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ps3_r     <= 64'(rem2_r) * 64'(step2_r);
      pe3_r     <= 56'(rem2_r) * 56'(cfg.decay_step);
      strong3_r <= strong2_r;
      act3_r    <= act2_r;
    end
  end

  // T4: table indexes
  logic [32+SIW:0] sprod;
  logic [24+EIW:0] eprod;
  logic [19:0]     n_int;
  logic [SIW-1:0]  sidx4_r;
  logic [EIW-1:0]  k4_r;
  logic [IEW-1:0]  n4_r;
  logic            nok4_r, strong4_r, act4_r;

  always_comb begin
    sprod = (33+SIW)'(ps3_r[43:12]) * (33+SIW)'(SINE_TABLE_DEPTH);
    eprod = (25+EIW)'(pe3_r[35:12]) * (25+EIW)'(ENVELOPE_TABLE_DEPTH);
    n_int = pe3_r[55:36];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidx4_r   <= sprod[32 +: SIW];
      k4_r      <= eprod[24 +: EIW];
      n4_r      <= n_int[IEW-1:0];
      nok4_r    <= (n_int < 20'(INT_EXP_COUNT));
      strong4_r <= strong3_r;
      act4_r    <= act3_r;
    end
  end

  // T5: table reads
  logic signed [15:0] sine5_r;
  logic [30:0]        frac5_r, int5_r;
  logic               strong5_r, act5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sine5_r   <= SINE_ROM[sidx4_r];
      frac5_r   <= FRAC_ROM[k4_r];
      int5_r    <= nok4_r ? INT_ROM[n4_r] : 31'd0;
      strong5_r <= strong4_r;
      act5_r    <= act4_r;
    end
  end

  // T6: envelope, Q1.30 rounded
  logic [61:0]        esum;
  logic [30:0]        env6_r;
  logic signed [15:0] sine6_r;
  logic               strong6_r, act6_r;

  always_comb begin
    esum = 62'(int5_r) * 62'(frac5_r) + 62'd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      env6_r    <= esum[60:30];
      sine6_r   <= sine5_r;
      strong6_r <= strong5_r;
      act6_r    <= act5_r;
    end
  end

  // T7: sine magnitude times envelope
  logic [15:0] smag;
  logic [45:0] m7_r;
  logic        sneg7_r, strong7_r, act7_r;

  always_comb begin
    smag = sine6_r[15] ? 16'(-sine6_r) : 16'(sine6_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m7_r      <= 46'(smag[14:0]) * 46'(env6_r);
      sneg7_r   <= sine6_r[15];
      strong7_r <= strong6_r;
      act7_r    <= act6_r;
    end
  end

  // T8: gain
  logic [60:0] p8_r;
  logic        sneg8_r, strong8_r, act8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p8_r      <= 61'(m7_r) * 61'(strong7_r ? GAIN_STRONG : GAIN_WEAK);
      sneg8_r   <= sneg7_r;
      strong8_r <= strong7_r;
      act8_r    <= act7_r;
    end
  end

  // T9: round half away from zero, saturate, sign; zero outside the click window
  logic [61:0]        pr;
  logic [16:0]        vmag;
  logic [16:0]        vsat;
  logic signed [15:0] sample_nxt;
  logic signed [15:0] sample9_r;
  logic               accent9_r;

  always_comb begin
    pr   = 62'(p8_r) + (62'd1 << 44);
    vmag = pr[61:45];
    if (sneg8_r) begin
      vsat       = (vmag > 17'd32768) ? 17'd32768 : vmag;
      sample_nxt = 16'(-vsat);
    end else begin
      vsat       = (vmag > 17'd32767) ? 17'd32767 : vmag;
      sample_nxt = vsat[15:0];
    end
    if (!act8_r) begin
      sample_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample9_r <= sample_nxt;
      accent9_r <= act8_r && strong8_r;
    end
  end

  // Valid and last along T1..T9
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= {last_r[7:0], in_last};
    end
  end

  assign out_v      = v_r[8];
  assign out_last   = last_r[8];
  assign out_sample = sample9_r;
  assign out_accent = accent9_r;

endmodule

>>> test/tb_metronome_click_synth.sv
`timescale 1ns / 1ps

module tb_metronome_click_synth;

  localparam int POS_W = 48;
  localparam int SINE_N = 1024;
  localparam int ENV_N = 1024;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_PI = 64'd3373259426;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_TWO_PI = 64'd6746518852;
  localparam int INT_EXP_N = 32;
  localparam longint unsigned ACCENT_GAIN = 64'd29491;
  localparam longint unsigned NORMAL_GAIN = 64'd19661;
  localparam int DUT_LATENCY = POS_W + 22;

  typedef struct {
    logic signed [POS_W-1:0] pos;
    logic last;
  } pos_item_t;

  typedef struct {
    logic signed [15:0] sample;
    logic accent;
    logic last;
  } click_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mcs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data;

  mcs_in_if #(.POSITION_BITS(POS_W)) in_chan ();
  mcs_out_if out_chan ();

  metronome_click_synth u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Lookup tables and tempo settings mirrored in the testbench
  int sine_lut[SINE_N];
  longint unsigned frac_env_lut[ENV_N];
  longint unsigned whole_env_lut[INT_EXP_N];
  logic [31:0] m_period;
  logic [6:0] m_bpb;
  logic [19:0] m_click_len;
  logic [31:0] m_accent_step;
  logic [31:0] m_normal_step;
  logic [23:0] m_decay;

  pos_item_t pending_pos[$];
  click_t expected_clicks[$];
  int fails = 0;
  bit calm_send = 0;
  bit calm_recv = 0;

  // Clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned sin_q30(longint unsigned a);
    longint signed sum;
    longint unsigned term;
    sum = a;
    term = a;
    for (int k = 1; k <= 12; k++) begin
      term = (((term * a) >> 30) * a) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k & 1) sum -= term;
      else sum += term;
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint signed sum;
    longint unsigned term;
    sum = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x) >> 30) / k;
      if (k & 1) sum -= term;
      else sum += term;
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  function automatic void fill_luts();
    longint unsigned x, v, e1;
    bit neg;
    for (int i = 0; i < SINE_N; i++) begin
      x = (longint'(i) * Q30_TWO_PI) / SINE_N;
      neg = 0;
      if (x >= Q30_PI) begin
        neg = 1;
        x -= Q30_PI;
      end
      if (x > Q30_HALF_PI) x = Q30_PI - x;
      v = (sin_q30(x) + (64'd1 << 14)) >> 15;
      if (v > 32767) v = 32767;
      sine_lut[i] = neg ? -int'(v) : int'(v);
    end
    for (int i = 0; i < ENV_N; i++)
      frac_env_lut[i] = exp_neg_q30((longint'(i) << 30) / ENV_N);
    e1 = exp_neg_q30(Q30_ONE);
    whole_env_lut[0] = Q30_ONE;
    for (int i = 1; i < INT_EXP_N; i++)
      whole_env_lut[i] = (whole_env_lut[i-1] * e1 + (64'd1 << 29)) >> 30;
  endfunction

  // Click sample for one playhead position under the current tempo settings
  function automatic click_t click_at(pos_item_t it);
    click_t r;
    longint unsigned mag, num, per, bpb, q, rem, qmod;
    longint unsigned step, phase, sidx, e24, n, env, smag, gain, p, v;
    int s;
    bit accent;
    r.sample = '0;
    r.accent = 0;
    r.last = it.last;
    per = m_period;
    bpb = (m_bpb == 0) ? 4 : m_bpb;
    if (per == 0) return r;
    // magnitude as unsigned, so the most negative position stays positive
    mag = it.pos[POS_W-1] ? longint'($unsigned(48'(-it.pos)))
                          : longint'($unsigned(48'(it.pos)));
    num = mag << 12;
    q = num / per;
    rem = num % per;
    qmod = q % bpb;
    if (it.pos[POS_W-1]) begin
      if (rem != 0) begin
        rem = per - rem;
        qmod = (qmod + 1) % bpb;
      end
      qmod = (bpb - qmod) % bpb;
    end
    if (rem >= (longint'(m_click_len) << 12)) return r;
    accent = (qmod == 0);
    step = accent ? m_accent_step : m_normal_step;
    phase = ((rem * step) >> 12) & 64'hFFFF_FFFF;
    sidx = (phase * SINE_N) >> 32;
    e24 = (rem * m_decay) >> 12;
    n = e24 >> 24;
    env = 0;
    if (n < INT_EXP_N)
      env = (whole_env_lut[n] * frac_env_lut[((e24 & 64'hFF_FFFF) * ENV_N) >> 24]
             + (64'd1 << 29)) >> 30;
    s = sine_lut[sidx];
    smag = (s < 0) ? -s : s;
    gain = accent ? ACCENT_GAIN : NORMAL_GAIN;
    p = smag * env * gain;
    v = (p + (64'd1 << 44)) >> 45;
    if (s < 0) begin
      if (v > 32768) v = 32768;
      r.sample = 16'(-v);
    end else begin
      if (v > 32767) v = 32767;
      r.sample = 16'(v);
    end
    r.accent = accent;
    return r;
  endfunction

  // Driver: one position per transfer, random gap after each unless calm_send
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_clicks.push_back(click_at('{in_chan.sample_position, in_chan.frame_last}));
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_pos.size() > 0) begin
          pos_item_t it;
          it = pending_pos.pop_front();
          in_chan.sample_position <= it.pos;
          in_chan.frame_last <= it.last;
          in_chan.valid <= 1'b1;
          send_gap = calm_send ? 0 : $urandom_range(0, 5);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  int recv_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_clicks.size() == 0) begin
          $display("%0t: unexpected result sample=%0d accent=%0b last=%0b", $time,
                   out_chan.click_sample, out_chan.accent_flag, out_chan.last_out);
          fails++;
        end else begin
          click_t e;
          e = expected_clicks.pop_front();
          if (out_chan.click_sample !== e.sample) begin
            $display("%0t: click_sample expected %0d actual %0d", $time, e.sample,
                     out_chan.click_sample);
            fails++;
          end
          if (out_chan.accent_flag !== e.accent) begin
            $display("%0t: accent_flag expected %0b actual %0b", $time, e.accent,
                     out_chan.accent_flag);
            fails++;
          end
          if (out_chan.last_out !== e.last) begin
            $display("%0t: last_out expected %0b actual %0b", $time, e.last,
                     out_chan.last_out);
            fails++;
          end
        end
        recv_stall = calm_recv ? 0 : $urandom_range(0, 5);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Write enable stays high across a burst; the caller drops it afterwards
  task automatic set_reg(mcs_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mcs_pkg::CFG_BEAT_PERIOD: m_period = val;
      mcs_pkg::CFG_BEATS_PER_BAR: m_bpb = val[6:0];
      mcs_pkg::CFG_CLICK_LENGTH: m_click_len = val[19:0];
      mcs_pkg::CFG_STRONG_STEP: m_accent_step = val;
      mcs_pkg::CFG_WEAK_STEP: m_normal_step = val;
      mcs_pkg::CFG_DECAY_STEP: m_decay = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_tempo(logic [31:0] per, logic [31:0] bpb, logic [31:0] len,
                           logic [31:0] acc, logic [31:0] nrm, logic [31:0] dec);
    set_reg(mcs_pkg::CFG_BEAT_PERIOD, per);
    set_reg(mcs_pkg::CFG_BEATS_PER_BAR, bpb);
    set_reg(mcs_pkg::CFG_CLICK_LENGTH, len);
    set_reg(mcs_pkg::CFG_STRONG_STEP, acc);
    set_reg(mcs_pkg::CFG_WEAK_STEP, nrm);
    set_reg(mcs_pkg::CFG_DECAY_STEP, dec);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pos(longint signed p);
    pending_pos.push_back('{p[POS_W-1:0], 1'($urandom)});
  endtask

  // Wait until every result is back and the pipeline has drained
  task automatic drain();
    while (pending_pos.size() > 0 || in_chan.valid || expected_clicks.size() > 0)
      @(posedge clk);
    repeat (DUT_LATENCY + 10) @(posedge clk);
  endtask

  // Random positions: mostly near beat starts so the click window is hit
  task automatic queue_random(int count);
    longint signed k, p, span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: p = longint'({$urandom, $urandom});
        2: p = longint'($urandom_range(0, 200000)) - 100000;
        default: begin
          k = longint'($urandom_range(0, 4000)) - 2000;
          span = longint'(m_click_len) + 4;
          if (span > 100000) span = 100000;
          p = ((k * longint'(m_period)) >>> 12) + longint'($urandom_range(0, span)) - 2;
        end
      endcase
      queue_pos(p);
    end
  endtask

  task automatic random_tempo();
    logic [31:0] per;
    per = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(4096, 1 << 24);
    set_tempo(per, $urandom_range(0, 64), $urandom_range(0, (per >> 12) + 20),
              $urandom, $urandom, $urandom_range(0, 1 << $urandom_range(8, 24)));
  endtask

  // Stimulus and phase sequencing
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.sample_position = '0;
    in_chan.frame_last = 1'b0;
    out_chan.ready = 1'b0;
    m_period = mcs_pkg::RST_BEAT_PERIOD;
    m_bpb = mcs_pkg::RST_BEATS_PER_BAR;
    m_click_len = mcs_pkg::RST_CLICK_LENGTH;
    m_accent_step = mcs_pkg::RST_STRONG_STEP;
    m_normal_step = mcs_pkg::RST_WEAK_STEP;
    m_decay = mcs_pkg::RST_DECAY_STEP;
    fill_luts();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset tempo, window edges, downbeat vs other beats, extremes, negatives
    queue_pos(0);
    queue_pos(1);
    queue_pos(1439);
    queue_pos(1440);
    queue_pos(24000);
    queue_pos(96000);
    queue_pos(-1);
    queue_pos(-24000);
    queue_pos(-23999);
    queue_pos(-96000 + 5);
    queue_pos(64'h0000_7FFF_FFFF_FFFF);
    queue_pos(-64'sh0000_8000_0000_0000);
    queue_pos(72000 + 700);
    queue_random(200);
    drain();

    // Zero beat period, zero beats per bar
    set_tempo(0, 0, 1440, mcs_pkg::RST_STRONG_STEP, mcs_pkg::RST_WEAK_STEP,
              mcs_pkg::RST_DECAY_STEP);
    queue_pos(0);
    queue_pos(5);
    queue_pos(-7);
    queue_random(20);
    drain();

    // Huge decay: envelope dies out inside a long window
    set_tempo(100 << 12, 0, 100, 32'h1234_5678, 32'h0876_5432, 24'hFF_FFFF);
    queue_pos(0);
    queue_pos(2);
    queue_pos(99);
    queue_pos(400);
    queue_pos(-300);
    queue_random(150);
    drain();

    // Maximum settings everywhere except beats per bar (64)
    set_tempo(32'hFFFF_FFFF, 64, 20'hF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_random(150);
    drain();

    // Minimum period, empty window, then one-beat bar with light decay
    set_tempo(4096, 1, 0, 0, 0, 0);
    queue_random(80);
    drain();
    set_tempo(4096 * 37 + 1234, 1, 37, 32'h0800_0000, 32'h0555_5555, 3);
    calm_send = 1;
    calm_recv = 1;
    queue_random(120);
    drain();
    calm_send = 0;
    calm_recv = 0;

    // Random tempos, some with back-to-back traffic
    for (int ph = 0; ph < 6; ph++) begin
      random_tempo();
      calm_send = ($urandom_range(0, 2) == 0);
      calm_recv = ($urandom_range(0, 2) == 0);
      queue_random(100);
      drain();
    end

    if (fails == 0 && expected_clicks.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
